@@ hw/rtl/cbwf_pkg.sv @@
package cbwf_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int ADDR_W        = 128;
    localparam int HALF_W        = 64;
    localparam int PLEN_W        = 8;
    localparam int OP_W          = 2;
    localparam int COUNT_OUT_W   = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [PLEN_W-1:0] PLEN_MAX = 8'd128;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              is_white;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
    } item_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

@@ hw/rtl/cbwf_front.sv @@
module cbwf_front
    import cbwf_pkg::*;
(
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic                    s_list_kind,
    input  logic [HALF_W-1:0]       s_address_high,
    input  logic [HALF_W-1:0]       s_address_low,
    input  logic [PLEN_W-1:0]       s_prefix_length,
    input  logic                    q_full,
    output logic                    q_push,
    output item_t                   q_push_item
);

    logic [PLEN_W-1:0] plen_sat;

    // Prefix lengths beyond the address width cover the whole address.
    assign plen_sat = (s_prefix_length > PLEN_MAX) ? PLEN_MAX : s_prefix_length;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_push_item.op       = s_operation;
        q_push_item.is_white = s_list_kind;
        q_push_item.addr     = {s_address_high, s_address_low};
        q_push_item.plen     = (s_operation == OP_ADD) ? plen_sat : '0;
    end

endmodule

@@ hw/rtl/cbwf_queue.sv @@
module cbwf_queue
    import cbwf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  item_t       push_item,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/cbwf_back.sv @@
module cbwf_back
    import cbwf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  queue_head_t            head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_allowed,
    output logic                   m_status,
    output logic [COUNT_OUT_W-1:0] m_black_count,
    output logic [COUNT_OUT_W-1:0] m_white_count
);

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int USE_W = CNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [PLEN_W-1:0] plen;
        logic              is_white;
    } entry_t;

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    entry_t            table_mem [MAX_RULES];
    entry_t            rd_data_reg;
    entry_t            wr_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  black_reg, black_next;
    logic [CNT_W-1:0]  white_reg, white_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              black_hit_reg, black_hit_next;
    logic              white_hit_reg, white_hit_next;
    logic [ADDR_W-1:0] chk_addr_reg, chk_addr_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_allowed_reg, out_allowed_next;
    logic              out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_black_reg, out_black_next;
    logic [CNT_W-1:0]  out_white_reg, out_white_next;

    logic [USE_W-1:0]  used;
    logic              out_free;
    logic              load_out;
    logic [ADDR_W-1:0] entry_mask;
    logic              entry_hit;

    assign used     = USE_W'(black_reg) + USE_W'(white_reg);
    assign out_free = !out_valid_reg || m_ready;

    assign entry_mask = ~(ALL_ONES >> rd_data_reg.plen);
    assign entry_hit  = (((chk_addr_reg ^ rd_data_reg.net) & entry_mask) == '0);

    always_comb begin
        state_next       = state_reg;
        black_next       = black_reg;
        white_next       = white_reg;
        issue_next       = issue_reg;
        rd_vld_next      = 1'b0;
        black_hit_next   = black_hit_reg;
        white_hit_next   = white_hit_reg;
        chk_addr_next    = chk_addr_reg;
        out_allowed_next = out_allowed_reg;
        out_status_next  = out_status_reg;
        load_out         = 1'b0;
        pop              = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = used[IDX_W-1:0];
        wr_data.net      = head.item.addr;
        wr_data.plen     = head.item.plen;
        wr_data.is_white = head.item.is_white;
        rd_en            = 1'b0;
        rd_addr          = issue_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (head.valid && out_free) begin
                    pop              = 1'b1;
                    out_allowed_next = 1'b0;
                    out_status_next  = 1'b0;
                    case (head.item.op)
                        OP_CLEAR: begin
                            black_next = '0;
                            white_next = '0;
                            load_out   = 1'b1;
                        end
                        OP_ADD: begin
                            load_out = 1'b1;
                            if (used >= USE_W'(MAX_RULES)) begin
                                out_status_next = 1'b1;
                            end else begin
                                wr_en = 1'b1;
                                if (head.item.is_white) begin
                                    white_next = white_reg + 1'b1;
                                end else begin
                                    black_next = black_reg + 1'b1;
                                end
                            end
                        end
                        OP_CHECK: begin
                            if (used == '0) begin
                                out_allowed_next = 1'b1;
                                load_out         = 1'b1;
                            end else begin
                                chk_addr_next  = head.item.addr;
                                issue_next     = '0;
                                black_hit_next = 1'b0;
                                white_hit_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Reads run one entry ahead of the compare.
                if (USE_W'(issue_reg) < used) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                if (rd_vld_reg && entry_hit) begin
                    if (rd_data_reg.is_white) begin
                        white_hit_next = 1'b1;
                    end else begin
                        black_hit_next = 1'b1;
                    end
                end
                if ((USE_W'(issue_reg) == used) && !rd_vld_reg && out_free) begin
                    out_allowed_next = !black_hit_reg && ((white_reg == '0) || white_hit_reg);
                    out_status_next  = 1'b0;
                    load_out         = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
            out_black_next = black_next;
            out_white_next = white_next;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
            out_black_next = out_black_reg;
            out_white_next = out_white_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            black_reg     <= '0;
            white_reg     <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            black_hit_reg <= 1'b0;
            white_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            black_reg     <= black_next;
            white_reg     <= white_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            black_hit_reg <= black_hit_next;
            white_hit_reg <= white_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_addr_reg    <= chk_addr_next;
        out_allowed_reg <= out_allowed_next;
        out_status_reg  <= out_status_next;
        out_black_reg   <= out_black_next;
        out_white_reg   <= out_white_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_allowed     = out_allowed_reg;
    assign m_status      = out_status_reg;
    assign m_black_count = COUNT_OUT_W'(out_black_reg);
    assign m_white_count = COUNT_OUT_W'(out_white_reg);

`ifndef SYNTH
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= USE_W'(MAX_RULES))
        else $error("rule table holds more entries than it has room for");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg) |-> (used == USE_W'(MAX_RULES)))
        else $error("table full reported while the table has room");

    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_status_reg && out_allowed_reg))
        else $error("result both allowed and flagged full");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("table read data pending outside a scan");

    a_no_pop_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !pop)
        else $error("queue popped while a check is in progress");
`endif

endmodule

@@ hw/rtl/cidr_blacklist_whitelist_filter.sv @@
// Prefix access filter over a table of up to MAX_RULES 128-bit networks, each
// tagged blacklist or whitelist; a small input queue lets new transfers be
// taken while the table engine works. Clear, add and unknown operations
// finish in the engine without a table scan. A check reads the table one
// entry per cycle through its single read port, once for each stored rule
// (an empty table is answered without a read). A check is denied on any
// blacklist hit, or when whitelist rules exist and none matches.
module cidr_blacklist_whitelist_filter
    import cbwf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic                   s_list_kind,
    input  logic [HALF_W-1:0]      s_address_high,
    input  logic [HALF_W-1:0]      s_address_low,
    input  logic [PLEN_W-1:0]      s_prefix_length,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_allowed,
    output logic                   m_status,
    output logic [COUNT_OUT_W-1:0] m_black_count,
    output logic [COUNT_OUT_W-1:0] m_white_count
);

    logic        q_full;
    logic        q_push;
    item_t       q_push_item;
    logic        q_pop;
    queue_head_t q_head;

    cbwf_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_list_kind     (s_list_kind),
        .s_address_high  (s_address_high),
        .s_address_low   (s_address_low),
        .s_prefix_length (s_prefix_length),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_push_item     (q_push_item)
    );

    cbwf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    cbwf_back #(
        .MAX_RULES (MAX_RULES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_allowed     (m_allowed),
        .m_status      (m_status),
        .m_black_count (m_black_count),
        .m_white_count (m_white_count)
    );

endmodule
